/* hw/rtl/point_deque_with_distance_select_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the point deque. Uses the clock and reset in scope.
// ---------------------------------------------------------------------------
`ifndef POINT_DEQUE_WITH_DISTANCE_SELECT_MACROS_SVH
`define POINT_DEQUE_WITH_DISTANCE_SELECT_MACROS_SVH

// same-cycle implication
`define PDQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pdq_pkg.sv */
// ---------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants of the point deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int COORD_WIDTH = 16;
   localparam int SQ_W        = 2 * COORD_WIDTH;
   localparam int DIST_W      = SQ_W + 2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   typedef enum logic [3:0] {
      OP_PUSH_TOP    = 4'd0,
      OP_POP_TOP     = 4'd1,
      OP_PUSH_BOTTOM = 4'd2,
      OP_POP_BOTTOM  = 4'd3,
      OP_COUNT       = 4'd4,
      OP_CLEAR       = 4'd5,
      OP_FAR         = 4'd6,
      OP_NEAR        = 4'd7,
      OP_SORT        = 4'd8
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/pdq_ram.sv */
// ---------------------------------------------------------------------------
// pdq_ram
// One-write one-read point memory, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdq_ram #(
   parameter int DEPTH = pdq_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire pdq_pkg::point_type  wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output      pdq_pkg::point_type  rd_data
);
   import pdq_pkg::*;

   point_type mem [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/pdq_dist.sv */
// ---------------------------------------------------------------------------
// pdq_dist
// Two-stage squared distance: squares, then sum. Tags ride along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdq_dist #(
   parameter int POS_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [POS_W-1:0]           in_pos,
   input  wire pdq_pkg::point_type         in_point,
   output      logic                       out_valid,
   output      logic [POS_W-1:0]           out_pos,
   output      pdq_pkg::point_type         out_point,
   output      logic [pdq_pkg::DIST_W-1:0] out_dist
);
   import pdq_pkg::*;

   logic                s1_valid_ff;
   logic [POS_W-1:0]    s1_pos_ff;
   point_type           s1_point_ff;
   logic [SQ_W-1:0]     sqx_ff, sqy_ff, sqz_ff;
   logic                s2_valid_ff;
   logic [POS_W-1:0]    s2_pos_ff;
   point_type           s2_point_ff;
   logic [DIST_W-1:0]   s2_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff   <= in_pos;
      s1_point_ff <= in_point;
      sqx_ff      <= SQ_W'(in_point.x * in_point.x);
      sqy_ff      <= SQ_W'(in_point.y * in_point.y);
      sqz_ff      <= SQ_W'(in_point.z * in_point.z);
      s2_pos_ff   <= s1_pos_ff;
      s2_point_ff <= s1_point_ff;
      s2_dist_ff  <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);
   end

   assign out_valid = s2_valid_ff;
   assign out_pos   = s2_pos_ff;
   assign out_point = s2_point_ff;
   assign out_dist  = s2_dist_ff;

endmodule

`default_nettype wire

/* hw/rtl/point_deque_with_distance_select.sv */
// Push, pop, count, clear and refused ops go through the hold state to the response register.
// Farthest / nearest: one memory read per cycle through the distance pipe.
// Sort: the whole memory is first saved to the copy, then count passes place one entry each.
// Sort restore: one entry per cycle through the copy path.
// Throughput: one word at a time; a new word is taken in idle even while a result waits.
// Reset clears counts and control; the point memories are not cleared.
// ---------------------------------------------------------------------------
// point_deque_with_distance_select
// Bounded deque of signed 3D points with farthest/nearest search and a
// sort toggle, held in two synchronous memories.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_deque_with_distance_select #(
   parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [3:0]                             req_opcode,
   input  wire logic signed [pdq_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [pdq_pkg::COORD_WIDTH-1:0] req_coord_y,
   input  wire logic signed [pdq_pkg::COORD_WIDTH-1:0] req_coord_z,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [1:0]                             rsp_status,
   output      logic [4:0]                             rsp_stored_count,
   output      logic                                   rsp_point_valid,
   output      logic signed [pdq_pkg::COORD_WIDTH-1:0] rsp_result_x,
   output      logic signed [pdq_pkg::COORD_WIDTH-1:0] rsp_result_y,
   output      logic signed [pdq_pkg::COORD_WIDTH-1:0] rsp_result_z
);
   import pdq_pkg::*;

`include "point_deque_with_distance_select_macros.svh"

   localparam int IW = $clog2(DEPTH);      // ring index
   localparam int CW = $clog2(DEPTH + 1);  // counts up to DEPTH

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_COPY = 5'b00010,   // whole-memory copy, save or restore
      S_SCAN = 5'b00100,   // one pass over the held entries
      S_FIN  = 5'b01000,   // pass result: answer or sorted write
      S_HOLD = 5'b10000    // result waits for the output register
   } state_type;

   // ring position to memory index, modulo DEPTH
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] b,
                                             input logic [IW-1:0] p);
      logic [IW:0] s;
      s = {1'b0, b} + {1'b0, p};
      if (s >= (IW+1)'(DEPTH)) begin
         s = s - (IW+1)'(DEPTH);
      end
      return s[IW-1:0];
   endfunction

   // control state
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      bottom_ff, bottom_in;
   logic               sorted_ff, sorted_in;
   logic [CW-1:0]      sv_count_ff, sv_count_in;
   logic [IW-1:0]      sv_bottom_ff, sv_bottom_in;
   logic [CW-1:0]      cp_idx_ff, cp_idx_in;     // copy read pointer
   logic               cp_v_ff, cp_v_in;         // copy write pending
   logic [CW-1:0]      scan_pos_ff, scan_pos_in; // read issue position
   logic [CW-1:0]      cmp_cnt_ff, cmp_cnt_in;   // entries compared
   logic               have_ff, have_in;
   logic [CW-1:0]      sort_k_ff, sort_k_in;     // next sorted slot
   logic [DEPTH-1:0]   used_ff, used_in;         // positions already placed
   logic               v1_ff, v1_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   opcode_type         op_ff, op_in;
   logic [IW-1:0]      cp_waddr_ff, cp_waddr_in;
   logic [IW-1:0]      p1_ff, p1_in;
   point_type          best_pt_ff, best_pt_in;
   logic [DIST_W-1:0]  best_d_ff, best_d_in;
   logic [IW-1:0]      best_pos_ff, best_pos_in;
   status_type         pend_status_ff, pend_status_in;
   logic               pend_pv_ff, pend_pv_in;
   point_type          pend_pt_ff, pend_pt_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_pv_ff, rsp_pv_in;
   point_type          rsp_pt_ff, rsp_pt_in;

   // memory ports
   logic               pt_we, sv_we;
   logic [IW-1:0]      pt_waddr, sv_waddr, pt_raddr, sv_raddr;
   point_type          pt_wdata, pt_rdata, sv_rdata;

   // distance pipe
   logic               d_valid;
   logic [IW-1:0]      d_pos;
   point_type          d_point;
   logic [DIST_W-1:0]  d_dist;

   point_type          req_point;
   logic               scan_issue, eligible, better;
   opcode_type         req_op;
   logic               push_take;                // accepted push with room

   assign req_point = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign req_op    = opcode_type'(req_opcode);
   assign push_take = req_valid && !req_stall && count_ff != CW'(DEPTH) &&
                      (req_op == OP_PUSH_TOP || req_op == OP_PUSH_BOTTOM);

   pdq_ram #(.DEPTH(DEPTH), .AW(IW)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   pdq_ram #(.DEPTH(DEPTH), .AW(IW)) u_saved_ram (
      .clock   (clock),
      .wr_en   (sv_we),
      .wr_addr (sv_waddr),
      .wr_data (pt_rdata),
      .rd_addr (sv_raddr),
      .rd_data (sv_rdata)
   );

   // sort passes read the saved copy; searches read the live store
   pdq_dist #(.POS_W(IW)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_pos    (p1_ff),
      .in_point  ((op_ff == OP_SORT) ? sv_rdata : pt_rdata),
      .out_valid (d_valid),
      .out_pos   (d_pos),
      .out_point (d_point),
      .out_dist  (d_dist)
   );

   // Main sequencer. The FSM serializes all memory traffic; where a read meets
   // a write to the same memory and entry in one cycle, its data is not used.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      bottom_in      = bottom_ff;
      sorted_in      = sorted_ff;
      sv_count_in    = sv_count_ff;
      sv_bottom_in   = sv_bottom_ff;
      cp_idx_in      = cp_idx_ff;
      cp_v_in        = 1'b0;
      scan_pos_in    = scan_pos_ff;
      cmp_cnt_in     = cmp_cnt_ff;
      have_in        = have_ff;
      sort_k_in      = sort_k_ff;
      used_in        = used_ff;
      v1_in          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      op_in          = op_ff;
      cp_waddr_in    = cp_waddr_ff;
      p1_in          = p1_ff;
      best_pt_in     = best_pt_ff;
      best_d_in      = best_d_ff;
      best_pos_in    = best_pos_ff;
      pend_status_in = pend_status_ff;
      pend_pv_in     = pend_pv_ff;
      pend_pt_in     = pend_pt_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_pv_in      = rsp_pv_ff;
      rsp_pt_in      = rsp_pt_ff;
      pt_we          = 1'b0;
      pt_waddr       = cp_waddr_ff;
      pt_wdata       = sv_rdata;
      sv_we          = 1'b0;
      sv_waddr       = cp_waddr_ff;
      pt_raddr       = slot_of(bottom_ff, scan_pos_ff[IW-1:0]);
      sv_raddr       = slot_of(bottom_ff, scan_pos_ff[IW-1:0]);
      scan_issue     = 1'b0;
      eligible       = 1'b0;
      better         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_op;
               pend_status_in = ST_OK;
               pend_pv_in     = 1'b0;
               state_in       = S_HOLD;
               case (req_op)
                  OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
                     sorted_in = 1'b0;
                     if (count_ff == CW'(DEPTH)) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        pt_we    = 1'b1;
                        pt_wdata = req_point;
                        count_in = count_ff + 1'b1;
                        if (req_op == OP_PUSH_TOP) begin
                           pt_waddr = slot_of(bottom_ff, count_ff[IW-1:0]);
                        end else begin
                           bottom_in = (bottom_ff == '0) ? IW'(DEPTH - 1)
                                                         : bottom_ff - 1'b1;
                           pt_waddr  = bottom_in;
                        end
                     end
                  end
                  OP_POP_TOP, OP_POP_BOTTOM: begin
                     sorted_in = 1'b0;
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        if (req_op == OP_POP_BOTTOM) begin
                           bottom_in = slot_of(bottom_ff, IW'(1));
                        end
                        count_in = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           bottom_in = '0;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     bottom_in = '0;
                  end
                  OP_FAR, OP_NEAR: begin
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        scan_pos_in = '0;
                        cmp_cnt_in  = '0;
                        have_in     = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_SORT: begin
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        cp_idx_in = '0;
                        state_in  = S_COPY;
                        if (!sorted_ff) begin
                           sv_bottom_in = bottom_ff;
                           sv_count_in  = count_ff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_COPY: begin
            // save: live -> saved; restore: saved -> live
            pt_raddr = cp_idx_ff[IW-1:0];
            sv_raddr = cp_idx_ff[IW-1:0];
            if (cp_idx_ff != CW'(DEPTH)) begin
               cp_idx_in   = cp_idx_ff + 1'b1;
               cp_v_in     = 1'b1;
               cp_waddr_in = cp_idx_ff[IW-1:0];
            end
            if (cp_v_ff) begin
               if (sorted_ff) begin
                  pt_we = 1'b1;
               end else begin
                  sv_we = 1'b1;
               end
            end
            if (cp_idx_ff == CW'(DEPTH) && !cp_v_ff) begin
               if (sorted_ff) begin
                  bottom_in = sv_bottom_ff;
                  count_in  = sv_count_ff;
                  sorted_in = 1'b0;
                  state_in  = S_HOLD;
               end else begin
                  used_in     = '0;
                  sort_k_in   = '0;
                  scan_pos_in = '0;
                  cmp_cnt_in  = '0;
                  have_in     = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            scan_issue = (scan_pos_ff != count_ff);
            if (scan_issue) begin
               scan_pos_in = scan_pos_ff + 1'b1;
               v1_in       = 1'b1;
               p1_in       = scan_pos_ff[IW-1:0];
            end
            if (d_valid) begin
               cmp_cnt_in = cmp_cnt_ff + 1'b1;
               eligible   = (op_ff != OP_SORT) || !used_ff[d_pos];
               // strict compare: ties keep the entry nearest the bottom
               better     = !have_ff || ((op_ff == OP_NEAR) ? (d_dist < best_d_ff)
                                                             : (d_dist > best_d_ff));
               if (eligible && better) begin
                  have_in     = 1'b1;
                  best_pt_in  = d_point;
                  best_d_in   = d_dist;
                  best_pos_in = d_pos;
               end
               if (CW'(cmp_cnt_ff + 1'b1) == count_ff) begin
                  state_in = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (op_ff == OP_SORT) begin
               pt_we                = 1'b1;
               pt_waddr             = sort_k_ff[IW-1:0];
               pt_wdata             = best_pt_ff;
               used_in[best_pos_ff] = 1'b1;
               sort_k_in            = sort_k_ff + 1'b1;
               if (CW'(sort_k_ff + 1'b1) == count_ff) begin
                  bottom_in = '0;
                  sorted_in = 1'b1;
                  state_in  = S_HOLD;
               end else begin
                  scan_pos_in = '0;
                  cmp_cnt_in  = '0;
                  have_in     = 1'b0;
                  state_in    = S_SCAN;
               end
            end else begin
               pend_pv_in = 1'b1;
               pend_pt_in = best_pt_ff;
               state_in   = S_HOLD;
            end
         end

         S_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = 5'(count_ff);
               rsp_pv_in     = pend_pv_ff;
               rsp_pt_in     = pend_pv_ff ? pend_pt_ff : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bottom_ff    <= '0;
         sorted_ff    <= 1'b0;
         sv_count_ff  <= '0;
         sv_bottom_ff <= '0;
         cp_idx_ff    <= '0;
         cp_v_ff      <= 1'b0;
         scan_pos_ff  <= '0;
         cmp_cnt_ff   <= '0;
         have_ff      <= 1'b0;
         sort_k_ff    <= '0;
         used_ff      <= '0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bottom_ff    <= bottom_in;
         sorted_ff    <= sorted_in;
         sv_count_ff  <= sv_count_in;
         sv_bottom_ff <= sv_bottom_in;
         cp_idx_ff    <= cp_idx_in;
         cp_v_ff      <= cp_v_in;
         scan_pos_ff  <= scan_pos_in;
         cmp_cnt_ff   <= cmp_cnt_in;
         have_ff      <= have_in;
         sort_k_ff    <= sort_k_in;
         used_ff      <= used_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      cp_waddr_ff    <= cp_waddr_in;
      p1_ff          <= p1_in;
      best_pt_ff     <= best_pt_in;
      best_d_ff      <= best_d_in;
      best_pos_ff    <= best_pos_in;
      pend_status_ff <= pend_status_in;
      pend_pv_ff     <= pend_pv_in;
      pend_pt_ff     <= pend_pt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_pv_ff      <= rsp_pv_in;
      rsp_pt_ff      <= rsp_pt_in;
   end

   // ports
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_point_valid  = rsp_pv_ff;
   assign rsp_result_x     = rsp_pt_ff.x;
   assign rsp_result_y     = rsp_pt_ff.y;
   assign rsp_result_z     = rsp_pt_ff.z;

   // checks
   `PDQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `PDQ_ASSERT_NOW(a_rsp_from_hold, $rose(rsp_valid_ff), $past(state_ff == S_HOLD), "no hold")
   `PDQ_ASSERT_NEXT(a_push_grows, push_take, count_ff == CW'($past(count_ff) + 1'b1), "push lost")

endmodule

`default_nettype wire
